// ----- hdl/lzwe_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared constants, result type and helper function of the LZW byte-stream
// encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 12;
    localparam int BITS_W  = 4;
    localparam int LIMIT_W = 13;

    // dictionary geometry
    localparam int DICT_ENTRIES = 4096;
    localparam int ALPHABET     = 256;
    localparam int IDX_W        = $clog2(DICT_ENTRIES);
    localparam int ADDR_W       = IDX_W + BYTE_W;
    localparam int TABLE_DEPTH  = DICT_ENTRIES * ALPHABET;
    localparam int WORD_W       = CODE_W + 1;

    // reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(DICT_ENTRIES);
    localparam logic [LIMIT_W-1:0] ENTRIES_RESET = LIMIT_W'(ALPHABET);
    localparam logic [LIMIT_W-1:0] ENTRIES_MAX   = LIMIT_W'(DICT_ENTRIES);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] code_bits;
        logic              final_res;
    } res_t;

    // ceil(log2(d)): number of bits needed to hold d-1
    function automatic logic [BITS_W-1:0] width_of(input logic [LIMIT_W-1:0] d);
        logic [LIMIT_W-1:0] m;
        logic [BITS_W-1:0]  w;
        m = (d == '0) ? '0 : d - LIMIT_W'(1);
        w = '0;
        for (int b = 0; b < LIMIT_W; b++)
        begin
            if (m[b])
            begin
                w = BITS_W'(b + 1);
            end
        end
        return w;
    endfunction

endpackage

// ----- hdl/lzwe_if.sv -----
// ----------------------------------------------------------------------------
// lzwe_if
// Valid/ready channels of the LZW encoder: raw bytes in, codes out.
// ----------------------------------------------------------------------------
interface lzwe_byte_if;
    logic                       valid;
    logic                       ready;
    logic [lzwe_pkg::BYTE_W-1:0] byte_in;
    logic                       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface lzwe_code_if;
    logic                        valid;
    logic                        ready;
    logic [lzwe_pkg::CODE_W-1:0] code;
    logic [lzwe_pkg::BITS_W-1:0] code_bits;
    logic                        final_res;

    modport source (output valid, output code, output code_bits, output final_res,
                    input ready);
    modport sink   (input valid, input code, input code_bits, input final_res,
                    output ready);
endinterface

// ----- hdl/lzw_byte_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// lzw_byte_stream_encoder
// LZW encoder with variable code width and a persistent dictionary.
// ----------------------------------------------------------------------------
// Path: a code passes the lookup stage register, then the queue register.
// Throughput: one byte per cycle while the queue has room for two codes; the
//   dictionary read issued at acceptance is resolved while the following byte
//   is looked up. Codes leave one per cycle while the sink is ready, so bytes
//   that give two codes can fill the queue and stall.
// Reset: the dictionary valid bits are cleared by a sweep over all 1048576
//   entries (one entry a cycle); no byte is accepted until it ends.
// ----------------------------------------------------------------------------
module lzw_byte_stream_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    lzwe_byte_if.sink                      in_bytes,
    lzwe_code_if.source                    out_codes,
    input  logic                           cfg_we,
    input  logic [lzwe_pkg::LIMIT_W-1:0]   cfg_wdata
);

    // configuration and encoder state
    logic [lzwe_pkg::LIMIT_W-1:0] limit_reg;
    logic [lzwe_pkg::CODE_W-1:0]  prefix_reg, prefix_next;
    logic                         active_reg, active_next;
    logic [lzwe_pkg::LIMIT_W-1:0] entries_reg, entries_next;

    // clearing sweep
    logic                         clr_busy_reg;
    logic [lzwe_pkg::ADDR_W-1:0]  clr_addr_reg;

    // lookup stage
    logic                         s1_valid_reg;
    logic [lzwe_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                         s1_last_reg;
    logic                         byp_reg;
    logic [lzwe_pkg::WORD_W-1:0]  byp_data_reg;

    logic                         accept;
    logic                         s1_done;
    logic                         room2;
    logic [lzwe_pkg::WORD_W-1:0]  ram_rdata;
    logic [lzwe_pkg::WORD_W-1:0]  look_word;
    logic                         hit;
    logic [lzwe_pkg::LIMIT_W-1:0] lim;
    logic                         emit_miss;
    logic                         add_entry;
    logic [lzwe_pkg::CODE_W-1:0]  eff_prefix;
    logic [lzwe_pkg::ADDR_W-1:0]  slot;
    logic [lzwe_pkg::ADDR_W-1:0]  rd_addr;
    logic                         ram_we;
    logic [lzwe_pkg::ADDR_W-1:0]  ram_waddr;
    logic [lzwe_pkg::WORD_W-1:0]  ram_wdata;
    logic [1:0]                   push_cnt;
    lzwe_pkg::res_t               res_miss, res_final, push0;

    // handshake: take a byte whenever the lookup stage frees up, outside the sweep
    assign s1_done        = s1_valid_reg && room2;
    assign in_bytes.ready = !clr_busy_reg && (!s1_valid_reg || s1_done);
    assign accept         = in_bytes.valid && in_bytes.ready;

    // resolve the lookup of the byte in the stage
    assign look_word = byp_reg ? byp_data_reg : ram_rdata;
    assign hit       = look_word[lzwe_pkg::WORD_W-1];
    assign lim       = (limit_reg > lzwe_pkg::ENTRIES_MAX) ? lzwe_pkg::ENTRIES_MAX : limit_reg;
    assign slot      = {prefix_reg[lzwe_pkg::IDX_W-1:0], s1_byte_reg};

    always_comb
    begin
        emit_miss    = 1'b0;
        add_entry    = 1'b0;
        prefix_next  = prefix_reg;
        entries_next = entries_reg;
        if (!active_reg)
        begin
            prefix_next = lzwe_pkg::CODE_W'(s1_byte_reg);
        end
        else if (hit)
        begin
            prefix_next = look_word[lzwe_pkg::CODE_W-1:0];
        end
        else
        begin
            emit_miss   = 1'b1;
            prefix_next = lzwe_pkg::CODE_W'(s1_byte_reg);
            if (entries_reg < lim)
            begin
                add_entry    = 1'b1;
                entries_next = entries_reg + lzwe_pkg::LIMIT_W'(1);
            end
        end
        active_next = !s1_last_reg;
    end

    // build results
    always_comb
    begin
        res_miss.code       = prefix_reg;
        res_miss.code_bits  = lzwe_pkg::width_of(entries_reg);
        res_miss.final_res  = 1'b0;
        res_final.code      = prefix_next;
        res_final.code_bits = lzwe_pkg::width_of(entries_next);
        res_final.final_res = 1'b1;
        push0               = emit_miss ? res_miss : res_final;
        push_cnt            = s1_done ? (2'(emit_miss) + 2'(s1_last_reg)) : 2'd0;
    end

    // next lookup uses the prefix the current byte leaves behind
    assign eff_prefix = s1_done ? prefix_next : prefix_reg;
    assign rd_addr    = {eff_prefix[lzwe_pkg::IDX_W-1:0], in_bytes.byte_in};

    // dictionary write port: clearing sweep or new entry
    assign ram_we    = clr_busy_reg || (s1_done && add_entry);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : slot;
    assign ram_wdata = clr_busy_reg ? '0
                                    : {1'b1, entries_reg[lzwe_pkg::CODE_W-1:0]};

    lzwe_ram #(
        .WIDTH (lzwe_pkg::WORD_W),
        .DEPTH (lzwe_pkg::TABLE_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    lzwe_res_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (res_final),
        .room2    (room2),
        .out      (out_codes)
    );

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lzwe_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // sweep the dictionary after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + lzwe_pkg::ADDR_W'(1);
            if (clr_addr_reg == {lzwe_pkg::ADDR_W{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // advance encoder state when the stage completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg   <= '0;
            active_reg   <= 1'b0;
            entries_reg  <= lzwe_pkg::ENTRIES_RESET;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (s1_done)
            begin
                prefix_reg  <= prefix_next;
                active_reg  <= active_next;
                entries_reg <= entries_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= ram_we && (ram_waddr == rd_addr);
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // capture the byte and any forwarded dictionary word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= in_bytes.byte_in;
            s1_last_reg  <= in_bytes.last_byte;
            byp_data_reg <= ram_wdata;
        end
    end

    // entry count stays within the dictionary
    assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg >= lzwe_pkg::ENTRIES_RESET && entries_reg <= lzwe_pkg::ENTRIES_MAX)
        else $error("entry count out of range");

    // a stalled lookup keeps its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_done |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("stalled lookup lost its byte");

    // every new entry bumps the count
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && !clr_busy_reg |=> entries_reg == $past(entries_reg) + 13'd1)
        else $error("entry added without count update");

    // a final byte ends the prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && s1_last_reg |=> !active_reg)
        else $error("prefix still active after last byte");

    // no byte is taken during the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s1_valid_reg)
        else $error("lookup during dictionary sweep");

endmodule

// ----- hdl/lzwe_ram.sv -----
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/lzwe_res_fifo.sv -----
// ----------------------------------------------------------------------------
// lzwe_res_fifo
// Small result queue: takes up to two codes per cycle, sends one per request.
// ----------------------------------------------------------------------------
module lzwe_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  lzwe_pkg::res_t     push0,
    input  lzwe_pkg::res_t     push1,
    output logic               room2,
    lzwe_code_if.source        out
);

    lzwe_pkg::res_t                    slot_reg [lzwe_pkg::FIFO_DEPTH];
    logic [lzwe_pkg::FIFO_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [lzwe_pkg::FIFO_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [lzwe_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [lzwe_pkg::FIFO_PTR_W-1:0]   wptr_plus1;
    logic                              pop;

    assign pop        = out.valid && out.ready;
    assign wptr_plus1 = wptr_reg + lzwe_pkg::FIFO_PTR_W'(1);
    assign room2      = count_reg <= lzwe_pkg::FIFO_CNT_W'(lzwe_pkg::FIFO_DEPTH - 2);

    // drive the head of the queue
    assign out.valid     = count_reg != '0;
    assign out.code      = slot_reg[rptr_reg].code;
    assign out.code_bits = slot_reg[rptr_reg].code_bits;
    assign out.final_res = slot_reg[rptr_reg].final_res;

    // advance pointers and count
    always_comb
    begin
        wptr_next  = wptr_reg + lzwe_pkg::FIFO_PTR_W'(push_cnt);
        rptr_next  = pop ? rptr_reg + lzwe_pkg::FIFO_PTR_W'(1) : rptr_reg;
        count_next = count_reg + lzwe_pkg::FIFO_CNT_W'(push_cnt)
                     - lzwe_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // store pushed results
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wptr_plus1] <= push1;
        end
    end

endmodule

// ----- test/tb_lzw_byte_stream_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzw_byte_stream_encoder
// Self-checking bench for the LZW byte-stream encoder. A clocked driver takes
// byte requests from a queue and predicts the codes of each accepted byte with
// a local dictionary model. A clocked monitor compares every code that leaves
// against the oldest prediction. The dictionary limit is moved through low,
// mid, clamped and zero settings between idle phases. Both sides idle in
// random bursts, and the code sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_lzw_byte_stream_encoder;

    localparam int CYCLE_LIMIT = 4 * 1_048_576 + 250_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AT_BYTE = 450;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [lzwe_pkg::BYTE_W-1:0] value;
        logic                        last;
    } raw_byte_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [lzwe_pkg::LIMIT_W-1:0] cfg_wdata;

    lzwe_byte_if bytes_if ();
    lzwe_code_if codes_if ();

    lzw_byte_stream_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (bytes_if),
        .out_codes (codes_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // byte requests waiting to be offered, codes waiting to arrive
    raw_byte_t      bytes_todo [$];
    lzwe_pkg::res_t codes_due [$];
    raw_byte_t      next_byte;
    lzwe_pkg::res_t want;

    int bytes_queued = 0;
    int bytes_taken = 0;
    int code_errors = 0;
    int cycle_count = 0;
    int src_gap = 0;
    int snk_gap = 0;

    logic src_idle = 1'b0;
    logic snk_idle = 1'b0;
    logic stall_sink = 1'b0;

    // local copy of the encoder state
    logic [lzwe_pkg::CODE_W-1:0]  dict_child [int];
    int                           entries = lzwe_pkg::ALPHABET;
    logic [lzwe_pkg::CODE_W-1:0]  pfx = '0;
    logic                         pfx_live = 1'b0;
    logic [lzwe_pkg::LIMIT_W-1:0] limit_m = lzwe_pkg::LIMIT_W'(lzwe_pkg::DICT_ENTRIES);

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // smallest width whose range covers n codes
    function automatic logic [lzwe_pkg::BITS_W-1:0] bits_for(input int n);
        int w;
        w = 0;
        while ((1 << w) < n)
            w++;
        return lzwe_pkg::BITS_W'(w);
    endfunction

    function automatic void push_code(input logic [lzwe_pkg::CODE_W-1:0] c,
                                      input logic fin);
        lzwe_pkg::res_t r;
        r.code      = c;
        r.code_bits = bits_for(entries);
        r.final_res = fin;
        codes_due.push_back(r);
    endfunction

    // advance the dictionary model by one byte, queueing the codes it gives
    task automatic encode_byte(input logic [lzwe_pkg::BYTE_W-1:0] b, input logic last);
        int slot;
        int cap;
        if (!pfx_live)
        begin
            pfx      = lzwe_pkg::CODE_W'(b);
            pfx_live = 1'b1;
        end
        else
        begin
            slot = int'({pfx, b});
            if (dict_child.exists(slot))
            begin
                pfx = dict_child[slot];
            end
            else
            begin
                cap = (int'(limit_m) > lzwe_pkg::DICT_ENTRIES) ? lzwe_pkg::DICT_ENTRIES
                                                               : int'(limit_m);
                push_code(pfx, 1'b0);
                if (entries < cap)
                begin
                    dict_child[slot] = lzwe_pkg::CODE_W'(entries);
                    entries++;
                end
                pfx = lzwe_pkg::CODE_W'(b);
            end
        end
        // flush the prefix at the end of a buffer
        if (last)
        begin
            push_code(pfx, 1'b1);
            pfx_live = 1'b0;
        end
    endtask

    // byte driver: predict on acceptance, then offer the next request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_if.valid     <= 1'b0;
            bytes_if.byte_in   <= '0;
            bytes_if.last_byte <= 1'b0;
        end
        else
        begin
            if (bytes_if.valid && bytes_if.ready)
            begin
                encode_byte(bytes_if.byte_in, bytes_if.last_byte);
                bytes_taken++;
            end
            if (!bytes_if.valid || bytes_if.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    bytes_if.valid <= 1'b0;
                end
                else if (src_idle && $urandom_range(0, 4) == 0)
                begin
                    src_gap = $urandom_range(0, 2);
                    bytes_if.valid <= 1'b0;
                end
                else if (bytes_todo.size() != 0)
                begin
                    next_byte = bytes_todo.pop_front();
                    bytes_if.valid     <= 1'b1;
                    bytes_if.byte_in   <= next_byte.value;
                    bytes_if.last_byte <= next_byte.last;
                end
                else
                begin
                    bytes_if.valid <= 1'b0;
                end
            end
        end
    end

    // code monitor: check each accepted code, then choose ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_if.ready <= 1'b0;
        end
        else
        begin
            if (codes_if.valid && codes_if.ready)
            begin
                if (codes_due.size() == 0)
                begin
                    code_errors++;
                    if (code_errors <= 10)
                        $display("unexpected code: code=%0d bits=%0d final=%0b",
                                 codes_if.code, codes_if.code_bits, codes_if.final_res);
                end
                else
                begin
                    want = codes_due.pop_front();
                    if (want.code != codes_if.code || want.code_bits != codes_if.code_bits
                        || want.final_res != codes_if.final_res)
                    begin
                        code_errors++;
                        if (code_errors <= 10)
                            $display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.code, want.code_bits, want.final_res,
                                     codes_if.code, codes_if.code_bits, codes_if.final_res);
                    end
                end
            end
            if (stall_sink)
            begin
                codes_if.ready <= 1'b0;
            end
            else if (snk_gap != 0)
            begin
                snk_gap--;
                codes_if.ready <= 1'b0;
            end
            else if (snk_idle && $urandom_range(0, 4) == 0)
            begin
                snk_gap = $urandom_range(0, 2);
                codes_if.ready <= 1'b0;
            end
            else
            begin
                codes_if.ready <= 1'b1;
            end
        end
    end

    // long hold-off on the code side so the result queue fills and input stalls
    initial
    begin
        while (bytes_taken < HOLD_AT_BYTE)
            @(posedge clk);
        stall_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_sink <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_byte(input logic [lzwe_pkg::BYTE_W-1:0] v, input logic last);
        raw_byte_t item;
        item.value = v;
        item.last  = last;
        bytes_todo.push_back(item);
        bytes_queued++;
    endtask

    // wait until every request is taken and every code is back, then drain
    task automatic settle();
        while (bytes_taken != bytes_queued || codes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [lzwe_pkg::LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        limit_m = v;
    endtask

    // random buffers, mostly well-formed runs that hit the dictionary
    task automatic add_random(input int count);
        int                          made;
        int                          len;
        int                          reps;
        int                          plen;
        int                          k;
        logic                        close;
        logic [lzwe_pkg::BYTE_W-1:0] base;
        logic [lzwe_pkg::BYTE_W-1:0] phrase [0:7];
        made = 0;
        while (made < count)
        begin
            close = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // uniform bytes exercise every bit of the field
                    len = $urandom_range(1, 12);
                    for (k = 0; k < len; k++)
                        add_byte(lzwe_pkg::BYTE_W'($urandom), close && (k == len - 1));
                end
                3, 4, 5:
                begin
                    // a narrow alphabet grows long chains of hits
                    base = lzwe_pkg::BYTE_W'($urandom);
                    len  = $urandom_range(4, 40);
                    for (k = 0; k < len; k++)
                        add_byte(base + lzwe_pkg::BYTE_W'($urandom_range(0, 3)),
                                 close && (k == len - 1));
                end
                6, 7, 8:
                begin
                    // a repeated phrase walks down its own entries
                    plen = $urandom_range(2, 6);
                    reps = $urandom_range(2, 6);
                    for (k = 0; k < plen; k++)
                        phrase[k] = lzwe_pkg::BYTE_W'($urandom);
                    len = plen * reps;
                    for (k = 0; k < len; k++)
                        add_byte(phrase[k % plen], close && (k == len - 1));
                end
                default:
                begin
                    // a lone byte, flushed at once
                    len = 1;
                    add_byte(lzwe_pkg::BYTE_W'($urandom), 1'b1);
                end
            endcase
            made += len;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // hold until the dictionary clearing sweep is over
        while (bytes_if.ready !== 1'b1)
            @(posedge clk);

        // low limit: one entry fits, then the dictionary is full
        write_limit(lzwe_pkg::LIMIT_W'(257));
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h41, 1'b0);
        settle();

        // raise the limit with a prefix still open
        write_limit(lzwe_pkg::LIMIT_W'(lzwe_pkg::DICT_ENTRIES));
        src_idle <= 1'b1;
        snk_idle <= 1'b1;
        add_byte(8'h42, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b1);
        add_byte(8'h80, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h04, 1'b0);
        add_byte(8'h08, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h40, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b1);
        add_random(300);
        settle();

        // mid limit, reached during the phase; no random sink idling, but the long sink hold-off falls here
        write_limit(lzwe_pkg::LIMIT_W'(600));
        snk_idle <= 1'b0;
        add_random(300);
        settle();

        // limit above the table size is clamped
        write_limit(lzwe_pkg::LIMIT_W'(8191));
        src_idle <= 1'b0;
        snk_idle <= 1'b1;
        add_random(250);
        settle();

        // zero limit: nothing is added
        write_limit(lzwe_pkg::LIMIT_W'(0));
        src_idle <= 1'b1;
        add_random(250);
        settle();

        // closing stretch at full speed
        write_limit(lzwe_pkg::LIMIT_W'(lzwe_pkg::DICT_ENTRIES));
        src_idle <= 1'b0;
        snk_idle <= 1'b0;
        add_random(500);
        settle();

        if (code_errors == 0 && codes_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lzwe_pkg.sv
hdl/lzwe_if.sv
hdl/lzwe_ram.sv
hdl/lzwe_res_fifo.sv
hdl/lzw_byte_stream_encoder.sv
test/tb_lzw_byte_stream_encoder.sv
